### rtl/acs_pkg.sv
// shared types and constants for the accumulator cpu step block
`timescale 1ns / 1ps
package acs_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_EXEC    = 2'd3;

  localparam logic [5:0] OP_READ   = 6'd10;
  localparam logic [5:0] OP_WRITE  = 6'd11;
  localparam logic [5:0] OP_LOAD   = 6'd20;
  localparam logic [5:0] OP_STORE  = 6'd21;
  localparam logic [5:0] OP_ADD    = 6'd30;
  localparam logic [5:0] OP_SUB    = 6'd31;
  localparam logic [5:0] OP_DIV    = 6'd32;
  localparam logic [5:0] OP_MUL    = 6'd33;
  localparam logic [5:0] OP_BR     = 6'd40;
  localparam logic [5:0] OP_BRNEG  = 6'd41;
  localparam logic [5:0] OP_BRZERO = 6'd42;

  localparam logic [2:0] STOP_RUN   = 3'd0;
  localparam logic [2:0] STOP_HALT  = 3'd1;
  localparam logic [2:0] STOP_DIVZ  = 3'd2;
  localparam logic [2:0] STOP_BADOP = 3'd3;
  localparam logic [2:0] STOP_PAST  = 3'd4;

  localparam int HALT_WORD = 9999;
  localparam int OP_SPLIT  = 100;
  // lowest word with a listed opcode and one past the highest word that decode lets through
  localparam int WORD_LO   = 1000;
  localparam int WORD_HI   = 4400;
  // opcode = (word * DIV_RECIP) >> DIV_SHIFT, exact for words below WORD_HI
  localparam int DIV_RECIP = 5243;
  localparam int DIV_SHIFT = 19;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [6:0]         address;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               value_valid;
    logic               input_taken;
    logic [6:0]         program_counter;
    logic signed [31:0] accumulator_value;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic wr_req;
    logic rd_req;
    logic restart;
    logic stop_pc;
    logic fetch;
    logic rd_data;
    logic decode;
    logic oper;
    logic exec;
    logic div_end;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       stopped;
    logic       pc_over;
    logic       dec_bad;
    logic       div_go;
    logic       div_done;
    logic       out_free;
  } dp_sts_t;

endpackage

### rtl/accumulator_cpu_step_top.sv
// top level of the accumulator cpu step block
`timescale 1ns / 1ps
// Accumulator machine with MEM_WORDS words of WORD_BITS-bit memory. Each input
// transfer writes or reads a word, restarts at address 0 or, unless stopped,
// executes one instruction, and yields exactly one result transfer with the
// state after it. One item is in flight at a time: an instruction steps
// through fetch, decode, operand read and execute over the single memory port,
// and a divide then runs in the bit-serial divider. Memory reads as zero after
// reset through per-word valid bits, so there is no clearing pass. The next
// item is accepted while a result still waits on the output register.
module accumulator_cpu_step_top #(
  parameter int MEM_WORDS = 100,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acs_pkg::out_item_t  out_data
);
  import acs_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  acs_dpath #(.MEM_WORDS(MEM_WORDS), .WORD_BITS(WORD_BITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/acs_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module acs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/acs_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module acs_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_BITS - 1);

  logic                 busy_r, done_r, neg_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [WORD_BITS-1:0] rem_r, quo_r, den_r;
  logic [WORD_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem_r, quo_r[WORD_BITS-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[WORD_BITS-1] ? -dividend : dividend;
      den_r <= divisor[WORD_BITS-1] ? -divisor : divisor;
      neg_r <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
    end else if (busy_r) begin
      rem_r <= fits ? WORD_BITS'(trial - {1'b0, den_r}) : trial[WORD_BITS-1:0];
      quo_r <= {quo_r[WORD_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

### rtl/acs_ctrl.sv
// sequencer for requests and instruction steps
`timescale 1ns / 1ps
module acs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  acs_pkg::dp_sts_t   sts,
  output acs_pkg::ctl_cmd_t  cmd
);
  import acs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_RDATA, S_DECODE, S_OPER, S_EXEC, S_DIV, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        case (sts.req_type)
          REQ_WRITE: begin
            cmd.wr_req = 1'b1;
            state_nxt  = S_RESP;
          end
          REQ_READ: begin
            cmd.rd_req = 1'b1;
            state_nxt  = S_RDATA;
          end
          REQ_RESTART: begin
            cmd.restart = 1'b1;
            state_nxt   = S_RESP;
          end
          default: begin
            if (sts.stopped) begin
              state_nxt = S_RESP;
            end else if (sts.pc_over) begin
              cmd.stop_pc = 1'b1;
              state_nxt   = S_RESP;
            end else begin
              cmd.fetch = 1'b1;
              state_nxt = S_DECODE;
            end
          end
        endcase
      end
      S_RDATA: begin
        cmd.rd_data = 1'b1;
        state_nxt   = S_RESP;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = sts.dec_bad ? S_RESP : S_OPER;
      end
      S_OPER: begin
        cmd.oper  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.div_go ? S_DIV : S_RESP;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_end = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### rtl/acs_dpath.sv
// datapath: memory, accumulator, counter, decode and result register
`timescale 1ns / 1ps
module acs_dpath #(
  parameter int MEM_WORDS = 100,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  acs_pkg::in_item_t   in_data,
  input  acs_pkg::ctl_cmd_t   cmd,
  output acs_pkg::dp_sts_t    sts,
  output logic                out_valid,
  input  logic                out_stall,
  output acs_pkg::out_item_t  out_data
);
  import acs_pkg::*;

  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam logic [6:0] MEM_LIM = 7'(MEM_WORDS);

  logic [1:0]           req_r;
  logic [6:0]           addr_r;
  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [6:0]           pc_r, pc_nxt;
  logic [2:0]           stop_r, stop_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic                 res_vld_r, res_vld_nxt;
  logic                 taken_r, taken_nxt;
  logic [5:0]           op_r;
  logic [12:0]          w13_r;
  logic [6:0]           opd_r;
  logic                 opd_ok_r;
  logic [MEM_WORDS-1:0] vld_r;
  logic                 vld_q_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic                 ram_we;
  logic [6:0]           ram_addr7;
  logic [WORD_BITS-1:0] ram_wdata, ram_q, mem_word;
  logic [25:0]          dec_prod;
  logic [6:0]           opd_calc;
  logic                 is_halt, is_bad;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_q;
  logic [6:0]           pc_inc;

  // words never written read as zero
  assign mem_word = vld_q_r ? ram_q : '0;
  assign pc_inc   = pc_r + 7'd1;

  assign is_halt  = $signed(mem_word) == HALT_WORD;
  assign is_bad   = ($signed(mem_word) < WORD_LO) || ($signed(mem_word) >= WORD_HI);
  assign dec_prod = 26'(mem_word[12:0]) * 26'(DIV_RECIP);
  assign opd_calc = 7'(w13_r - 13'(op_r) * 13'(OP_SPLIT));

  always_comb begin
    ram_we    = 1'b0;
    ram_addr7 = pc_r;
    ram_wdata = data_r;
    if (cmd.wr_req || cmd.rd_req) begin
      ram_addr7 = addr_r;
      ram_we    = cmd.wr_req && (addr_r < MEM_LIM);
    end else if (cmd.oper) begin
      ram_addr7 = opd_calc;
    end else if (cmd.exec) begin
      ram_addr7 = opd_r;
      if (op_r == OP_READ) begin
        ram_we = opd_ok_r;
      end else if (op_r == OP_STORE) begin
        ram_we    = opd_ok_r;
        ram_wdata = acc_r;
      end
    end
  end

  acs_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr7[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  acs_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && sts.div_go),
    .dividend (acc_r),
    .divisor  (mem_word),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    acc_nxt     = acc_r;
    pc_nxt      = pc_r;
    stop_nxt    = stop_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    taken_nxt   = taken_r;
    if (cmd.capture) begin
      res_nxt     = '0;
      res_vld_nxt = 1'b0;
      taken_nxt   = 1'b0;
    end
    if (cmd.restart) begin
      pc_nxt   = '0;
      stop_nxt = STOP_RUN;
    end
    if (cmd.stop_pc) begin
      stop_nxt = STOP_PAST;
    end
    if (cmd.rd_data && (addr_r < MEM_LIM)) begin
      res_nxt     = mem_word;
      res_vld_nxt = 1'b1;
    end
    if (cmd.decode) begin
      if (is_halt) begin
        stop_nxt = STOP_HALT;
      end else if (is_bad) begin
        stop_nxt = STOP_BADOP;
      end
    end
    if (cmd.exec) begin
      pc_nxt = pc_inc;
      case (op_r)
        OP_READ:  taken_nxt = 1'b1;
        OP_WRITE: begin
          res_nxt     = mem_word;
          res_vld_nxt = 1'b1;
        end
        OP_LOAD:  acc_nxt = mem_word;
        OP_STORE: acc_nxt = acc_r;
        OP_ADD:   acc_nxt = acc_r + mem_word;
        OP_SUB:   acc_nxt = acc_r - mem_word;
        OP_MUL:   acc_nxt = WORD_BITS'(acc_r * mem_word);
        OP_DIV: begin
          // counter moves once the quotient is in
          pc_nxt = pc_r;
          if (mem_word == '0) begin
            stop_nxt = STOP_DIVZ;
          end
        end
        OP_BR:     pc_nxt = opd_r;
        OP_BRNEG:  pc_nxt = acc_r[WORD_BITS-1] ? opd_r : pc_inc;
        OP_BRZERO: pc_nxt = (acc_r == '0) ? opd_r : pc_inc;
        default: begin
          pc_nxt   = pc_r;
          stop_nxt = STOP_BADOP;
        end
      endcase
    end
    if (cmd.div_end) begin
      acc_nxt = div_q;
      pc_nxt  = pc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pc_r        <= '0;
      stop_r      <= STOP_RUN;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      stop_r <= stop_nxt;
      if (ram_we) begin
        vld_r[ram_addr7[ADDR_W-1:0]] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    res_vld_r <= res_vld_nxt;
    taken_r   <= taken_nxt;
    vld_q_r   <= (ram_addr7 < MEM_LIM) && vld_r[ram_addr7[ADDR_W-1:0]];
    if (cmd.capture) begin
      req_r  <= in_data.req_type;
      addr_r <= in_data.address;
      data_r <= in_data.data_value[WORD_BITS-1:0];
    end
    if (cmd.decode) begin
      op_r  <= dec_prod[DIV_SHIFT+5:DIV_SHIFT];
      w13_r <= mem_word[12:0];
    end
    if (cmd.oper) begin
      opd_r    <= opd_calc;
      opd_ok_r <= opd_calc < MEM_LIM;
    end
    if (cmd.load_out) begin
      out_r.result_value      <= 32'($signed(res_nxt));
      out_r.value_valid       <= res_vld_nxt;
      out_r.input_taken       <= taken_nxt;
      out_r.program_counter   <= pc_nxt;
      out_r.accumulator_value <= 32'($signed(acc_nxt));
      out_r.status            <= stop_nxt;
    end
  end

  assign sts.req_type = req_r;
  assign sts.stopped  = stop_r != STOP_RUN;
  assign sts.pc_over  = pc_r >= MEM_LIM;
  assign sts.dec_bad  = is_halt || is_bad;
  assign sts.div_go   = (op_r == OP_DIV) && (mem_word != '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
